// ===== rtl/core/ott_pkg.sv =====
// Shared types, constants and the 5x7 font table for the OLED text terminal.
// No dependencies; used by oled_text_terminal and ott_checker.
package ott_pkg;

	// Display geometry
	localparam logic [2:0] LAST_LINE  = 3'd3;
	localparam logic [7:0] WRAP_LIMIT = 8'd127;
	localparam logic [7:0] GLYPH_STEP = 8'd6;
	localparam logic [7:0] WRAP_GUARD = 8'd10;
	localparam logic [7:0] COL_OFFSET = 8'd4;

	// Controller command bytes
	localparam logic [7:0] CMD_PAGE    = 8'hB0;
	localparam logic [7:0] CMD_COL_HI  = 8'h10;
	localparam logic [7:0] CMD_COL_LO4 = 8'h04;
	localparam logic [7:0] BLANK_BYTE  = 8'h00;

	// Character codes
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [6:0] GLYPH_BASE   = 7'h20;

	// Request kinds on the input channel
	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_CURSOR = 1'b1;

	// Result run sizing
	localparam int RUN_MAX   = 10;
	localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
	localparam int PRE_MAX   = 4;
	localparam int SUF_MAX   = 7;
	localparam int GLYPH_CNT = 96;

	typedef enum logic [1:0] {
		ITEM_CMD   = 2'd0,
		ITEM_DATA  = 2'd1,
		ITEM_CLEAR = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] value;
		logic       last;
	} run_entry_t;

	// Five columns per glyph, first column in the top byte
	localparam logic [39:0] FONT [GLYPH_CNT] = '{
		40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14,
		40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
		40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
		40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
		40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
		40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
		40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
		40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
		40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
		40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
		40'h00007f0000, 40'h0041360800, 40'h0201020402, 40'h0000000000
	};

endpackage

// ===== rtl/core/oled_text_terminal.sv =====
// Text console front end for a page-mode OLED controller with a 5x7 font.
// Depends on ott_pkg (types, command constants, font table).
//
// - Input channel (in_valid / in_stall): one request per accepted edge.
//   kind = 0 writes a character, kind = 1 loads the cursor (line, column).
// - Output channel (out_valid / out_stall): one controller item per accepted
//   edge; item_type 0 = command, 1 = display data, 2 = clear request (byte 0);
//   last marks the final item of the run belonging to one character request.
// - A character yields 3 to 10 items: positioning (3 commands, or 4 items with
//   a clear when the cursor wraps off the last line), then five glyph columns
//   and a blank column, or for a newline an optional clear. A cursor load
//   yields nothing.
// - An accepted request passes the input stage, then the run buffer, then
//   the output register before the first item of its run shows on out_valid.
// - Throughput: one item per cycle while out_stall does not hold the output;
//   runs follow each other without a gap; a cursor load yields no items and
//   does not wait for the run buffer.
// - in_stall rises only while the input stage holds a character the run
//   buffer cannot take yet; an output stall holds a valid item in place.
// - Reset (arst_n low) empties every stage; cursor goes to line 0, column 0.
module oled_text_terminal (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] character,
	input  logic [2:0] cursor_line,
	input  logic [6:0] cursor_column,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] item_type,
	output logic [7:0] byte_value,
	output logic       last
);
	import ott_pkg::*;

	// Input stage
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] char_s1;
	logic [2:0] cline_s1;
	logic [6:0] ccol_s1;

	// Cursor
	logic [2:0] line_q;
	logic [6:0] col_q;

	// Run buffer, drained from entry 0
	run_entry_t           run_q [RUN_MAX];
	logic [RUN_CNT_W-1:0] rem_q;

	// Output register
	logic       out_valid_q;
	run_entry_t out_q;

	// Handshake and stage control
	logic in_take;
	logic out_free;
	logic emit;
	logic run_open;
	logic s1_move;
	logic load_run;

	// Run built from the request in the input stage
	run_entry_t           new_run [RUN_MAX];
	logic [RUN_CNT_W-1:0] new_cnt;
	logic [2:0]           new_line;
	logic [6:0]           new_col;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (rem_q != '0) && out_free;
	// Buffer can take a new run at this edge if empty or its last item leaves now
	assign run_open = (rem_q == '0) || ((rem_q == RUN_CNT_W'(1)) && out_free);
	assign s1_move  = valid_s1 && ((kind_s1 == KIND_CURSOR) || run_open);
	assign load_run = s1_move && (kind_s1 == KIND_CHAR);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	// Build the item run and the next cursor for the request in the input stage
	always_comb begin
		logic                 wrap;
		run_entry_t           pre [PRE_MAX];
		run_entry_t           suf [SUF_MAX];
		logic [2:0]           pre_n;
		logic [2:0]           suf_n;
		logic [2:0]           l_mid;
		logic [6:0]           c_mid;
		logic [7:0]           col4;
		logic [6:0]           code;
		logic [6:0]           gidx;
		logic [39:0]          glyph;
		logic [RUN_CNT_W-1:0] j;

		for (int k = 0; k < PRE_MAX; k++) begin
			pre[k] = '{kind: ITEM_CMD, value: BLANK_BYTE, last: 1'b0};
		end
		for (int k = 0; k < SUF_MAX; k++) begin
			suf[k] = '{kind: ITEM_DATA, value: BLANK_BYTE, last: 1'b0};
		end

		// Positioning
		wrap = ({1'b0, col_q} + WRAP_GUARD) > WRAP_LIMIT;
		col4 = {1'b0, col_q} + COL_OFFSET;
		if (wrap) begin
			pre[0].value = CMD_COL_LO4;
			pre[1].value = CMD_COL_HI;
			c_mid = '0;
			if (line_q < LAST_LINE) begin
				l_mid        = line_q + 3'd1;
				pre[2].value = CMD_PAGE | {5'd0, l_mid};
				pre_n        = 3'd3;
			end else begin
				l_mid        = '0;
				pre[2].kind  = ITEM_CLEAR;
				pre[3].value = CMD_PAGE;
				pre_n        = 3'd4;
			end
		end else begin
			l_mid        = line_q;
			c_mid        = col_q;
			pre[0].value = CMD_PAGE | {5'd0, line_q};
			pre[1].value = {4'd0, col4[3:0]};
			pre[2].value = CMD_COL_HI + {4'd0, col4[7:4]};
			pre_n        = 3'd3;
		end

		// Glyph lookup; control codes map to the blank glyph
		code  = char_s1[6:0];
		gidx  = (code < GLYPH_BASE) ? '0 : (code - GLYPH_BASE);
		glyph = FONT[gidx];

		if (char_s1 == CHAR_NEWLINE) begin
			new_col  = '0;
			new_line = (l_mid < LAST_LINE) ? (l_mid + 3'd1) : 3'd0;
			suf[0]   = '{kind: ITEM_CLEAR, value: BLANK_BYTE, last: 1'b0};
			suf_n    = (new_line == 3'd0) ? 3'd1 : 3'd0;
		end else begin
			new_col  = c_mid + GLYPH_STEP[6:0];
			new_line = l_mid;
			for (int k = 0; k < 5; k++) begin
				suf[k].value = glyph[39 - 8*k -: 8];
			end
			suf_n = 3'd6;
		end

		new_cnt = RUN_CNT_W'(pre_n) + RUN_CNT_W'(suf_n);

		// Splice prefix and suffix
		for (int i = 0; i < RUN_MAX; i++) begin
			j = RUN_CNT_W'(i) - RUN_CNT_W'(pre_n);
			if (RUN_CNT_W'(i) < RUN_CNT_W'(pre_n)) begin
				new_run[i] = pre[i % PRE_MAX];
			end else begin
				new_run[i] = suf[j[2:0]];
			end
			new_run[i].last = (RUN_CNT_W'(i) == (new_cnt - RUN_CNT_W'(1)));
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1  <= kind;
			char_s1  <= character;
			cline_s1 <= cursor_line;
			ccol_s1  <= cursor_column;
		end
	end

	// Cursor advances as each request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			col_q  <= '0;
		end else if (s1_move) begin
			if (kind_s1 == KIND_CURSOR) begin
				line_q <= cline_s1;
				col_q  <= ccol_s1;
			end else begin
				line_q <= new_line;
				col_q  <= new_col;
			end
		end
	end

	// Run buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load_run) begin
			rem_q <= new_cnt;
		end else if (emit) begin
			rem_q <= rem_q - RUN_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_run) begin
			run_q <= new_run;
		end else if (emit) begin
			for (int k = 0; k < RUN_MAX - 1; k++) begin
				run_q[k] <= run_q[k + 1];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= run_q[0];
		end
	end

	assign out_valid  = out_valid_q;
	assign item_type  = out_q.kind;
	assign byte_value = out_q.value;
	assign last       = out_q.last;

endmodule

// ===== rtl/core/ott_checker.sv =====
// Port-level checks for oled_text_terminal, attached by bind.
// Depends on ott_pkg for item codes.
module ott_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       kind,
	input logic [7:0] character,
	input logic [2:0] cursor_line,
	input logic [6:0] cursor_column,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] item_type,
	input logic [7:0] byte_value,
	input logic       last
);
	import ott_pkg::*;

	// Stalled request stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=>
			in_valid && $stable(kind) && $stable(character) &&
			$stable(cursor_line) && $stable(cursor_column))
		else $error("request changed while stalled");

	// Held output while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(item_type) && $stable(byte_value) && $stable(last))
		else $error("output changed while stalled");

	// Clear requests carry no byte
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_type == ITEM_CLEAR) |-> (byte_value == BLANK_BYTE))
		else $error("clear request with nonzero byte");

	// Font columns use seven pixel rows; a glyph run ends on the blank column
	a_data_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_type == ITEM_DATA) |->
			!byte_value[7] && (!last || (byte_value == BLANK_BYTE)))
		else $error("bad display data byte");

	// A run that follows straight on the previous last item opens with a command
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && !out_stall && last) && out_valid |-> (item_type == ITEM_CMD))
		else $error("run does not start with a command");

endmodule

bind oled_text_terminal ott_checker u_ott_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.kind          (kind),
	.character     (character),
	.cursor_line   (cursor_line),
	.cursor_column (cursor_column),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.item_type     (item_type),
	.byte_value    (byte_value),
	.last          (last)
);
